FILE: rtl/core/flp_pkg.sv
package flp_pkg;

    // Counter width used for positions and digit counts.
    localparam int COUNT_BITS_DEF = 16;

    // Fixed widths of the result fields.
    localparam int OUT_CNT_W = 16;

    // Character codes the parser looks at.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_A     = 8'h41;

    // Sign codes.
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    // Special-value codes.
    localparam logic [2:0] SPC_NUM  = 3'd0;
    localparam logic [2:0] SPC_PINF = 3'd1;
    localparam logic [2:0] SPC_NINF = 3'd2;
    localparam logic [2:0] SPC_IND  = 3'd3;
    localparam logic [2:0] SPC_NAN  = 3'd4;

    // Most exponent digits allowed.
    localparam logic [2:0] EXP_MAX = 3'd4;

    // One character moving from the input register into the parser.
    typedef struct packed {
        logic       fire;
        logic       is_end;
        logic [7:0] char_byte;
    } t_step;

    // One result item.
    typedef struct packed {
        logic                 valid_res;
        logic [2:0]           special_code;
        logic [1:0]           lead_sign;
        logic [1:0]           exp_sign;
        logic [OUT_CNT_W-1:0] int_digits;
        logic [OUT_CNT_W-1:0] frac_digits;
        logic [2:0]           exp_digits;
        logic [OUT_CNT_W-1:0] literal_start;
        logic [OUT_CNT_W-1:0] literal_length;
    } t_result;

    // Space, tab, LF, VT, FF and CR.
    function automatic logic flp_is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic flp_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Lower-case letters map to upper case; everything else passes.
    function automatic logic [7:0] flp_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

endpackage

FILE: rtl/core/flp_in_stage.sv
module flp_in_stage
    import flp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_end,
    input  logic       i_out_free,
    output t_step      o_step
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_end;
    logic       fire;

    // A character moves on at once; an end item waits for a free result slot.
    assign fire    = r_valid && (!r_end || i_out_free);
    assign o_ready = !r_valid || fire;

    assign o_step.fire      = fire;
    assign o_step.is_end    = r_end;
    assign o_step.char_byte = r_char;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_byte;
            r_end  <= i_is_end;
        end
    end

endmodule

FILE: rtl/core/flp_parse.sv
module flp_parse
    import flp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_strict,
    input  t_step   i_step,
    output t_result o_result
);

    // Parse phases.
    localparam logic [3:0] PH_LEAD     = 4'd0;
    localparam logic [3:0] PH_SIGN     = 4'd1;
    localparam logic [3:0] PH_MAG_I    = 4'd2;
    localparam logic [3:0] PH_MAG_N    = 4'd3;
    localparam logic [3:0] PH_INT      = 4'd4;
    localparam logic [3:0] PH_FRAC     = 4'd5;
    localparam logic [3:0] PH_EXP_SIGN = 4'd6;
    localparam logic [3:0] PH_EXP_DIG  = 4'd7;
    localparam logic [3:0] PH_TRAIL    = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;
    localparam logic [3:0] PH_REJECT   = 4'd10;

    logic                  r_strict;
    logic [3:0]            r_phase,  n_phase;
    logic [1:0]            r_magic,  n_magic;
    logic [COUNT_BITS-1:0] r_position, n_position;
    logic [COUNT_BITS-1:0] r_int_count, n_int_count;
    logic [COUNT_BITS-1:0] r_frac_count, n_frac_count;
    logic [2:0]            r_exp_count, n_exp_count;
    logic [1:0]            r_lead_sign, n_lead_sign;
    logic [1:0]            r_exp_sign, n_exp_sign;
    logic [2:0]            r_special, n_special;
    logic [COUNT_BITS-1:0] r_start, n_start;
    logic [COUNT_BITS-1:0] r_length, n_length;

    logic [7:0]            c;
    logic [7:0]            u;
    logic                  ws;
    logic                  dg;
    logic [3:0]            body_phase;
    logic [3:0]            stop_phase;
    logic [COUNT_BITS-1:0] pos_inc;
    logic [COUNT_BITS-1:0] len_now;
    logic [COUNT_BITS-1:0] len_magic;
    logic [COUNT_BITS-1:0] len_final;
    logic                  ok;

    logic [COUNT_BITS+OUT_CNT_W-1:0] int_ext;
    logic [COUNT_BITS+OUT_CNT_W-1:0] frac_ext;
    logic [COUNT_BITS+OUT_CNT_W-1:0] start_ext;
    logic [COUNT_BITS+OUT_CNT_W-1:0] len_ext;

    // Character classes of the current character.
    assign c  = i_step.char_byte;
    assign u  = flp_upper(c);
    assign ws = flp_is_ws(c);
    assign dg = flp_is_digit(c);

    // Saturating position step and literal lengths.
    assign pos_inc   = (&r_position) ? r_position : r_position + 1'b1;
    assign len_now   = r_position - r_start;
    assign len_magic = pos_inc - r_start;

    // Phase a character takes when it opens the body of the literal.
    always_comb begin
        if (dg) begin
            body_phase = PH_INT;
        end else if (c == CH_POINT) begin
            body_phase = PH_FRAC;
        end else if (u == CH_I) begin
            body_phase = PH_MAG_I;
        end else if (u == CH_N) begin
            body_phase = PH_MAG_N;
        end else begin
            body_phase = PH_REJECT;
        end
    end

    // Phase after a character that ends a numeric literal.
    always_comb begin
        if (ws) begin
            stop_phase = PH_TRAIL;
        end else if (r_strict) begin
            stop_phase = PH_REJECT;
        end else begin
            stop_phase = PH_DONE;
        end
    end

    // Next parse state for one character.
    always_comb begin
        n_phase      = r_phase;
        n_magic      = r_magic;
        n_position   = r_position;
        n_int_count  = r_int_count;
        n_frac_count = r_frac_count;
        n_exp_count  = r_exp_count;
        n_lead_sign  = r_lead_sign;
        n_exp_sign   = r_exp_sign;
        n_special    = r_special;
        n_start      = r_start;
        n_length     = r_length;

        if (i_step.fire && !i_step.is_end) begin
            n_position = pos_inc;
            case (r_phase)
                PH_LEAD: begin
                    if (!ws) begin
                        n_start = r_position;
                        if (c == CH_PLUS) begin
                            n_lead_sign = SIGN_PLUS;
                            n_phase     = PH_SIGN;
                        end else if (c == CH_MINUS) begin
                            n_lead_sign = SIGN_MINUS;
                            n_phase     = PH_SIGN;
                        end else begin
                            n_phase     = body_phase;
                            n_magic     = 2'd1;
                            n_int_count = dg ? COUNT_BITS'(1) : r_int_count;
                        end
                    end
                end
                PH_SIGN: begin
                    n_phase     = body_phase;
                    n_magic     = 2'd1;
                    n_int_count = dg ? COUNT_BITS'(1) : r_int_count;
                end
                PH_MAG_I: begin
                    if (r_magic == 2'd1 && u == CH_N) begin
                        n_magic = 2'd2;
                    end else if (r_magic == 2'd2 && u == CH_F) begin
                        n_special = (r_lead_sign == SIGN_MINUS) ? SPC_NINF : SPC_PINF;
                        n_length  = len_magic;
                        n_phase   = PH_TRAIL;
                    end else if (r_magic == 2'd2 && u == CH_D) begin
                        n_special = SPC_IND;
                        n_length  = len_magic;
                        n_phase   = PH_TRAIL;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_MAG_N: begin
                    if (r_magic == 2'd1 && u == CH_A) begin
                        n_magic = 2'd2;
                    end else if (r_magic == 2'd2 && u == CH_N) begin
                        n_special = SPC_NAN;
                        n_length  = len_magic;
                        n_phase   = PH_TRAIL;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_INT: begin
                    if (dg) begin
                        n_int_count = (&r_int_count) ? r_int_count : r_int_count + 1'b1;
                    end else if (c == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else if (u == CH_E) begin
                        n_phase = PH_EXP_SIGN;
                    end else begin
                        n_length = len_now;
                        n_phase  = stop_phase;
                    end
                end
                PH_FRAC: begin
                    if (dg) begin
                        n_frac_count = (&r_frac_count) ? r_frac_count
                                                       : r_frac_count + 1'b1;
                    end else if (r_int_count == '0 && r_frac_count == '0) begin
                        n_phase = PH_REJECT;
                    end else if (u == CH_E) begin
                        n_phase = PH_EXP_SIGN;
                    end else begin
                        n_length = len_now;
                        n_phase  = stop_phase;
                    end
                end
                PH_EXP_SIGN: begin
                    if (c == CH_PLUS) begin
                        n_exp_sign = SIGN_PLUS;
                        n_phase    = PH_EXP_DIG;
                    end else if (c == CH_MINUS) begin
                        n_exp_sign = SIGN_MINUS;
                        n_phase    = PH_EXP_DIG;
                    end else if (dg) begin
                        n_exp_count = 3'd1;
                        n_phase     = PH_EXP_DIG;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_EXP_DIG: begin
                    if (dg) begin
                        if (r_exp_count >= EXP_MAX) begin
                            n_phase = PH_REJECT;
                        end else begin
                            n_exp_count = r_exp_count + 3'd1;
                        end
                    end else if (r_exp_count == 3'd0) begin
                        n_phase = PH_REJECT;
                    end else begin
                        n_length = len_now;
                        n_phase  = stop_phase;
                    end
                end
                PH_TRAIL: begin
                    if (!ws) begin
                        n_phase = r_strict ? PH_REJECT : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_step.fire) begin
            // The end item closes the string and clears the parse state.
            n_phase      = PH_LEAD;
            n_magic      = 2'd0;
            n_position   = '0;
            n_int_count  = '0;
            n_frac_count = '0;
            n_exp_count  = 3'd0;
            n_lead_sign  = SIGN_NONE;
            n_exp_sign   = SIGN_NONE;
            n_special    = SPC_NUM;
            n_start      = '0;
            n_length     = '0;
        end
    end

    // Judgment of the string at the end item.
    always_comb begin
        ok        = 1'b0;
        len_final = r_length;
        case (r_phase)
            PH_INT: begin
                ok        = 1'b1;
                len_final = len_now;
            end
            PH_FRAC: begin
                ok        = (r_int_count != '0) || (r_frac_count != '0);
                len_final = len_now;
            end
            PH_EXP_DIG: begin
                ok        = (r_exp_count != 3'd0);
                len_final = len_now;
            end
            PH_TRAIL, PH_DONE: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Counts are zero-extended and cut to the result width.
    assign int_ext   = {{OUT_CNT_W{1'b0}}, r_int_count};
    assign frac_ext  = {{OUT_CNT_W{1'b0}}, r_frac_count};
    assign start_ext = {{OUT_CNT_W{1'b0}}, r_start};
    assign len_ext   = {{OUT_CNT_W{1'b0}}, len_final};

    // A rejected string gives a result of all zeros.
    always_comb begin
        o_result = '0;
        if (ok) begin
            o_result.valid_res      = 1'b1;
            o_result.special_code   = r_special;
            o_result.lead_sign      = r_lead_sign;
            o_result.exp_sign       = r_exp_sign;
            o_result.int_digits     = int_ext[OUT_CNT_W-1:0];
            o_result.frac_digits    = frac_ext[OUT_CNT_W-1:0];
            o_result.exp_digits     = r_exp_count;
            o_result.literal_start  = start_ext[OUT_CNT_W-1:0];
            o_result.literal_length = len_ext[OUT_CNT_W-1:0];
        end
    end

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_strict;
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_magic      <= 2'd0;
            r_position   <= '0;
            r_int_count  <= '0;
            r_frac_count <= '0;
            r_exp_count  <= 3'd0;
            r_lead_sign  <= SIGN_NONE;
            r_exp_sign   <= SIGN_NONE;
            r_special    <= SPC_NUM;
            r_start      <= '0;
            r_length     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_magic      <= n_magic;
            r_position   <= n_position;
            r_int_count  <= n_int_count;
            r_frac_count <= n_frac_count;
            r_exp_count  <= n_exp_count;
            r_lead_sign  <= n_lead_sign;
            r_exp_sign   <= n_exp_sign;
            r_special    <= n_special;
            r_start      <= n_start;
            r_length     <= n_length;
        end
    end

    // After an end item the parser starts over at position zero.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.fire && i_step.is_end |=> r_phase == PH_LEAD && r_position == '0)
        else $error("parse state not cleared after end item");

    // The literal never starts past the current position.
    a_start_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_position)
        else $error("literal start beyond current position");

    // The exponent digit count stays within its limit.
    a_exp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_count <= EXP_MAX)
        else $error("exponent digit count over limit");

    // A closed literal fits between its start and the current position.
    a_trail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRAIL |-> r_length <= r_position - r_start)
        else $error("held literal length too long");

endmodule

FILE: rtl/core/flp_out_stage.sv
module flp_out_stage
    import flp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // The slot can take a new result when empty or when it drains this cycle.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/float_literal_parser_core.sv
// Floating-point literal recognizer. The block takes one character per transfer
// on the input channel and one transfer can complete in every clock cycle; an
// item marked as the end of the string produces one result transfer giving
// validity, special-value code, signs, digit counts and the literal's start
// and length. A character passes an input register, then updates the parse
// state; an end item's result loads into the output register as the end item
// leaves the input register. The input stalls only while an end item waits for
// the output register to drain. The strict-mode register resets to 1 and is
// written over its own channel; the user must do so only while idle, unchecked.
module float_literal_parser_core
    import flp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_strict_mode,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_is_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_valid_res,
    output logic [2:0]           o_special_code,
    output logic [1:0]           o_lead_sign,
    output logic [1:0]           o_exp_sign,
    output logic [OUT_CNT_W-1:0] o_int_digits,
    output logic [OUT_CNT_W-1:0] o_frac_digits,
    output logic [2:0]           o_exp_digits,
    output logic [OUT_CNT_W-1:0] o_literal_start,
    output logic [OUT_CNT_W-1:0] o_literal_length
);

    t_step   step;
    t_result parse_result;
    t_result out_result;
    logic    out_free;

    assign o_cfg_ready = 1'b1;

    flp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_char_byte (i_char_byte),
        .i_is_end    (i_is_end),
        .i_out_free  (out_free),
        .o_step      (step)
    );

    flp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_strict (i_cfg_strict_mode),
        .i_step       (step),
        .o_result     (parse_result)
    );

    flp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step.fire && step.is_end),
        .i_result (parse_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    // Result fields onto their ports.
    assign o_valid_res      = out_result.valid_res;
    assign o_special_code   = out_result.special_code;
    assign o_lead_sign      = out_result.lead_sign;
    assign o_exp_sign       = out_result.exp_sign;
    assign o_int_digits     = out_result.int_digits;
    assign o_frac_digits    = out_result.frac_digits;
    assign o_exp_digits     = out_result.exp_digits;
    assign o_literal_start  = out_result.literal_start;
    assign o_literal_length = out_result.literal_length;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import flp_pkg::*;

    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_WAIT = 6;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Parse phases of the predictor.
    typedef enum logic [3:0] {
        SC_LEAD, SC_SIGN, SC_MAG_I, SC_MAG_N, SC_INT, SC_FRAC,
        SC_EXP_SIGN, SC_EXP_DIG, SC_TRAIL, SC_DONE, SC_REJECT
    } t_scan_phase;

    // One character of a string, or its terminator.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_valid  = 1'b0;
    logic       cfg_strict = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] in_char    = 8'h00;
    logic       in_end     = 1'b0;
    logic       out_ready  = 1'b0;

    wire                 o_cfg_ready;
    wire                 o_in_ready;
    wire                 o_out_valid;
    wire                 o_valid_res;
    wire [2:0]           o_special_code;
    wire [1:0]           o_lead_sign;
    wire [1:0]           o_exp_sign;
    wire [OUT_CNT_W-1:0] o_int_digits;
    wire [OUT_CNT_W-1:0] o_frac_digits;
    wire [2:0]           o_exp_digits;
    wire [OUT_CNT_W-1:0] o_literal_start;
    wire [OUT_CNT_W-1:0] o_literal_length;

    t_char_item char_queue[$];
    t_result    expected_verdicts[$];
    int         queued_items = 0;
    int         error_count  = 0;
    int         result_index = 0;
    bit         no_idle      = 1'b0;
    int         send_hold    = 0;
    int         recv_hold    = 0;
    int         quiet_cycles = 0;

    // Predictor state.
    logic        sc_strict = 1'b1;
    t_scan_phase sc_phase;
    logic [1:0]  sc_magic;
    logic [15:0] sc_pos;
    logic [15:0] sc_int;
    logic [15:0] sc_frac;
    logic [2:0]  sc_exp;
    logic [1:0]  sc_lead_sign;
    logic [1:0]  sc_exp_sign;
    logic [2:0]  sc_special;
    logic [15:0] sc_start;
    logic [15:0] sc_length;

    float_literal_parser_core uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_strict_mode (cfg_strict),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_byte       (in_char),
        .i_is_end          (in_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_valid_res       (o_valid_res),
        .o_special_code    (o_special_code),
        .o_lead_sign       (o_lead_sign),
        .o_exp_sign        (o_exp_sign),
        .o_int_digits      (o_int_digits),
        .o_frac_digits     (o_frac_digits),
        .o_exp_digits      (o_exp_digits),
        .o_literal_start   (o_literal_start),
        .o_literal_length  (o_literal_length)
    );

    always #6 clk = ~clk;

    // Character classes of the literal grammar.
    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= DIGIT_ZERO && c <= DIGIT_ZERO + 8'd9;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - CASE_BIT : c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic clear_scan();
        sc_phase     = SC_LEAD;
        sc_magic     = 2'd0;
        sc_pos       = '0;
        sc_int       = '0;
        sc_frac      = '0;
        sc_exp       = '0;
        sc_lead_sign = SIGN_NONE;
        sc_exp_sign  = SIGN_NONE;
        sc_special   = SPC_NUM;
        sc_start     = '0;
        sc_length    = '0;
    endtask

    // The literal ends before this character; the character decides what follows.
    task automatic close_literal(input logic [7:0] c);
        sc_length = sc_pos - sc_start;
        if (is_space(c)) begin
            sc_phase = SC_TRAIL;
        end else begin
            sc_phase = sc_strict ? SC_REJECT : SC_DONE;
        end
    endtask

    // This character is the last letter of Inf, Ind or NaN.
    task automatic close_special(input logic [2:0] code);
        sc_special = code;
        sc_length  = sat_inc(sc_pos) - sc_start;
        sc_phase   = SC_TRAIL;
    endtask

    task automatic open_body(input logic [7:0] c);
        logic [7:0] u;
        u = to_upper(c);
        if (is_digit(c)) begin
            sc_int   = 16'd1;
            sc_phase = SC_INT;
        end else if (c == CH_POINT) begin
            sc_phase = SC_FRAC;
        end else if (u == CH_I) begin
            sc_magic = 2'd1;
            sc_phase = SC_MAG_I;
        end else if (u == CH_N) begin
            sc_magic = 2'd1;
            sc_phase = SC_MAG_N;
        end else begin
            sc_phase = SC_REJECT;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [7:0] u;
        u = to_upper(c);
        case (sc_phase)
            SC_LEAD: begin
                if (!is_space(c)) begin
                    sc_start = sc_pos;
                    if (c == CH_PLUS) begin
                        sc_lead_sign = SIGN_PLUS;
                        sc_phase     = SC_SIGN;
                    end else if (c == CH_MINUS) begin
                        sc_lead_sign = SIGN_MINUS;
                        sc_phase     = SC_SIGN;
                    end else begin
                        open_body(c);
                    end
                end
            end
            SC_SIGN: open_body(c);
            SC_MAG_I: begin
                if (sc_magic == 2'd1 && u == CH_N) begin
                    sc_magic = 2'd2;
                end else if (sc_magic == 2'd2 && u == CH_F) begin
                    close_special(sc_lead_sign == SIGN_MINUS ? SPC_NINF : SPC_PINF);
                end else if (sc_magic == 2'd2 && u == CH_D) begin
                    close_special(SPC_IND);
                end else begin
                    sc_phase = SC_REJECT;
                end
            end
            SC_MAG_N: begin
                if (sc_magic == 2'd1 && u == CH_A) begin
                    sc_magic = 2'd2;
                end else if (sc_magic == 2'd2 && u == CH_N) begin
                    close_special(SPC_NAN);
                end else begin
                    sc_phase = SC_REJECT;
                end
            end
            SC_INT: begin
                if (is_digit(c)) begin
                    sc_int = sat_inc(sc_int);
                end else if (c == CH_POINT) begin
                    sc_phase = SC_FRAC;
                end else if (u == CH_E) begin
                    sc_phase = SC_EXP_SIGN;
                end else begin
                    close_literal(c);
                end
            end
            SC_FRAC: begin
                if (is_digit(c)) begin
                    sc_frac = sat_inc(sc_frac);
                end else if (sc_int == 0 && sc_frac == 0) begin
                    sc_phase = SC_REJECT;
                end else if (u == CH_E) begin
                    sc_phase = SC_EXP_SIGN;
                end else begin
                    close_literal(c);
                end
            end
            SC_EXP_SIGN: begin
                if (c == CH_PLUS) begin
                    sc_exp_sign = SIGN_PLUS;
                    sc_phase    = SC_EXP_DIG;
                end else if (c == CH_MINUS) begin
                    sc_exp_sign = SIGN_MINUS;
                    sc_phase    = SC_EXP_DIG;
                end else if (is_digit(c)) begin
                    sc_exp   = 3'd1;
                    sc_phase = SC_EXP_DIG;
                end else begin
                    sc_phase = SC_REJECT;
                end
            end
            SC_EXP_DIG: begin
                if (is_digit(c)) begin
                    if (sc_exp >= EXP_MAX) begin
                        sc_phase = SC_REJECT;
                    end else begin
                        sc_exp = sc_exp + 3'd1;
                    end
                end else if (sc_exp == 0) begin
                    sc_phase = SC_REJECT;
                end else begin
                    close_literal(c);
                end
            end
            SC_TRAIL: begin
                if (!is_space(c)) begin
                    sc_phase = sc_strict ? SC_REJECT : SC_DONE;
                end
            end
            default: ;
        endcase
        sc_pos = sat_inc(sc_pos);
    endtask

    // Terminator: judge the string and queue the verdict.
    task automatic scan_end();
        t_result v;
        bit      ok;
        ok = 1'b0;
        case (sc_phase)
            SC_INT: begin
                ok        = 1'b1;
                sc_length = sc_pos - sc_start;
            end
            SC_FRAC: begin
                ok        = (sc_int != 0 || sc_frac != 0);
                sc_length = sc_pos - sc_start;
            end
            SC_EXP_DIG: begin
                ok        = (sc_exp != 0);
                sc_length = sc_pos - sc_start;
            end
            SC_TRAIL, SC_DONE: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        v = '0;
        if (ok) begin
            v.valid_res      = 1'b1;
            v.special_code   = sc_special;
            v.lead_sign      = sc_lead_sign;
            v.exp_sign       = sc_exp_sign;
            v.int_digits     = sc_int;
            v.frac_digits    = sc_frac;
            v.exp_digits     = sc_exp;
            v.literal_start  = sc_start;
            v.literal_length = sc_length;
        end
        expected_verdicts.push_back(v);
        clear_scan();
    endtask

    // Idle lengths: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_error(input string text);
        error_count++;
        if (error_count <= 10) $display("%s", text);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            note_error($sformatf("result %0d: %s expected %0d, got %0d",
                                 result_index, name, want, got));
        end
    endtask

    // Input driver: takes the next character when the previous transfer is done.
    always @(posedge clk) begin
        t_char_item item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_hold = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                if (in_end) scan_end();
                else scan_char(in_char);
            end
            if (!in_valid || o_in_ready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    in_valid <= 1'b0;
                end else if (char_queue.size() != 0) begin
                    item = char_queue.pop_front();
                    in_char  <= item.ch;
                    in_end   <= item.last;
                    in_valid <= 1'b1;
                    send_hold = no_idle ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares every result transfer with the oldest verdict.
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    note_error($sformatf("result %0d arrived with none expected",
                                         result_index));
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("valid_res", 32'(want.valid_res), 32'(o_valid_res));
                    check_field("special_code", 32'(want.special_code),
                                32'(o_special_code));
                    check_field("lead_sign", 32'(want.lead_sign), 32'(o_lead_sign));
                    check_field("exp_sign", 32'(want.exp_sign), 32'(o_exp_sign));
                    check_field("int_digits", 32'(want.int_digits),
                                32'(o_int_digits));
                    check_field("frac_digits", 32'(want.frac_digits),
                                32'(o_frac_digits));
                    check_field("exp_digits", 32'(want.exp_digits),
                                32'(o_exp_digits));
                    check_field("literal_start", 32'(want.literal_start),
                                32'(o_literal_start));
                    check_field("literal_length", 32'(want.literal_length),
                                32'(o_literal_length));
                end
                result_index++;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) recv_hold = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        t_char_item item;
        item.ch   = c;
        item.last = 1'b0;
        char_queue.push_back(item);
        queued_items++;
    endtask

    // The character on the terminator is a don't-care, so it is random.
    task automatic push_end();
        t_char_item item;
        item.ch   = 8'($urandom_range(0, 255));
        item.last = 1'b1;
        char_queue.push_back(item);
        queued_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic push_string(input string s);
        push_text(s);
        push_end();
    endtask

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
    endfunction

    function automatic logic [7:0] pick_digit();
        return DIGIT_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic push_digits(input int n);
        repeat (n) push_char(pick_digit());
    endtask

    // Inf, Ind or NaN in mixed case, sometimes broken or cut short.
    task automatic push_special();
        logic [7:0] word[3];
        int         cut;
        case ($urandom_range(0, 2))
            0: word = '{CH_I, CH_N, CH_F};
            1: word = '{CH_I, CH_N, CH_D};
            default: word = '{CH_N, CH_A, CH_N};
        endcase
        cut = 3;
        if ($urandom_range(0, 9) == 0) begin
            word[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, 2);
        for (int i = 0; i < cut; i++) begin
            push_char($urandom_range(0, 1) ? (word[i] | CASE_BIT) : word[i]);
        end
    endtask

    task automatic push_number();
        int ni;
        int nf;
        int r;
        bit point;
        ni    = $urandom_range(0, 4);
        point = 1'($urandom_range(0, 1));
        nf    = point ? $urandom_range(0, 4) : 0;
        if (ni == 0 && nf == 0 && $urandom_range(0, 9) != 0) ni = 1;
        push_digits(ni);
        if (point) push_char(CH_POINT);
        push_digits(nf);
        if ($urandom_range(0, 99) < 35) begin
            push_char($urandom_range(0, 1) ? (CH_E | CASE_BIT) : CH_E);
            case ($urandom_range(0, 2))
                0: push_char(CH_PLUS);
                1: push_char(CH_MINUS);
                default: ;
            endcase
            r = $urandom_range(0, 99);
            if (r < 5) push_digits(0);
            else if (r < 10) push_digits(5);
            else push_digits($urandom_range(1, 4));
        end
    endtask

    // Mostly well-formed literals with random content, some noise.
    task automatic push_random_string();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) push_char(pick_space());
            case ($urandom_range(0, 3))
                0: push_char(CH_PLUS);
                1: push_char(CH_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 99) < 15) push_special();
            else push_number();
            if ($urandom_range(0, 99) < 25) repeat ($urandom_range(0, 2)) push_char(pick_space());
            if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) begin
                push_char(8'($urandom_range(0, 255)));
            end
        end
        push_end();
    endtask

    task automatic push_random(input int n);
        int first;
        first = queued_items;
        while (queued_items - first < n) push_random_string();
    endtask

    // Short strings covering every form and the corner cases of the grammar.
    task automatic push_directed();
        push_end();
        push_string("  +12.5e-3  ");
        push_string("-inf");
        push_string("+Inf");
        push_string("iNd");
        push_string("-NaN");
        push_string("nan");
        push_string("Infinity");
        push_string(".");
        push_string(".5");
        push_string("5.");
        push_string("1e");
        push_string("1e+");
        push_string("1E-1234");
        push_string("1e12345");
        for (int c = CH_TAB; c <= 8'h0D; c++) push_char(8'(c));
        push_string(" 7");
        push_text("12");
        push_char(8'h00);
        push_string("3");
        push_string("12abc");
        push_string("INX");
        push_string("na");
        push_char(8'hFF);
        push_char(8'h80);
        push_end();
        push_string("x123");
        push_string("-.e1");
        push_string("0009.0100E+09  ");
        push_string("1 2");
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (char_queue.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_strict(input logic value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        cfg_strict <= value;
        do @(posedge clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sc_strict = value;
        repeat (2) @(posedge clk);
    endtask

    // Test sequence: strict and relaxed phases, directed strings first.
    initial begin
        clear_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        push_directed();
        wait_idle();
        write_strict(1'b0);
        push_directed();
        wait_idle();
        write_strict(1'b1);
        push_random(130);
        wait_idle();
        write_strict(1'b0);
        push_random(130);
        wait_idle();
        write_strict(1'b1);
        no_idle = 1'b1;
        push_random(70);
        wait_idle();

        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/flp_pkg.sv
rtl/core/flp_in_stage.sv
rtl/core/flp_parse.sv
rtl/core/flp_out_stage.sv
rtl/core/float_literal_parser_core.sv
bench/testbench.sv
